@@ src/qdra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdra_pkg: shared definitions for the quaternion delta rotation accumulator
// Fixed-point widths, scale constants, the CORDIC arctangent table and the
// status type of the iterative arithmetic units.
// ----------------------------------------------------------------------------
package qdra_pkg;

	// sample and total formats
	localparam int QUAT_W  = 16;
	localparam int ANGLE_W = 32;
	localparam int QFRAC   = QUAT_W - 2;
	localparam int DFRAC   = 28;

	// internal working widths
	localparam int DQ_W    = 32;
	localparam int WIDE_W  = 64;
	localparam int ROOT_W  = 32;
	localparam int QUOT_W  = 32;
	localparam int QBITS_W = 5;
	localparam int MUL_W   = 33;
	localparam int AQ_W    = 32;

	// CORDIC vectoring
	localparam int CORDIC_STEPS = 28;
	localparam int CK_W         = 5;
	localparam int XY_W         = 34;
	localparam int Z_W          = 33;
	localparam int ATAN_W       = 31;

	// near-zero thresholds
	localparam logic [ROOT_W-1:0] IN_EPS    = ROOT_W'((2 ** QFRAC) / 1000000);
	localparam logic [ROOT_W-1:0] DELTA_EPS = ROOT_W'(268);

	// quotient lengths of the three divide uses
	localparam logic [QBITS_W-1:0] IN_QBITS  = QBITS_W'(QFRAC + 2);
	localparam logic [QBITS_W-1:0] DL_QBITS  = QBITS_W'(DFRAC + 2);
	localparam logic [QBITS_W-1:0] INC_QBITS = QBITS_W'(18);

	// radians * 2^30 to full angle in 1/256 degree * 2^16
	localparam logic [MUL_W-1:0] DEG_SCALE = MUL_W'(64'd1922527338);
	localparam int DEG_SHIFT = 30;
	localparam int INC_SHIFT = 16;

	// subtracted terms of conj(last) * current, bit = row * 4 + term
	localparam logic [15:0] DELTA_NEG = 16'b1010_1100_0110_0000;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// arctangent of 2^-k in radians * 2^30
	function automatic logic [ATAN_W-1:0] atan_step(input logic [CK_W-1:0] k);
		logic [ATAN_W-1:0] v;
		case (k)
			5'd0: v = 31'd843314857;
			5'd1: v = 31'd497837829;
			5'd2: v = 31'd263043837;
			5'd3: v = 31'd133525159;
			5'd4: v = 31'd67021687;
			5'd5: v = 31'd33543516;
			5'd6: v = 31'd16775851;
			5'd7: v = 31'd8388437;
			5'd8: v = 31'd4194283;
			5'd9: v = 31'd2097149;
			default: v = 31'd1 << (5'd30 - k);
		endcase
		return v;
	endfunction

endpackage

@@ src/qdra_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdra_div: iterative restoring divider
// Unsigned long division, one quotient bit per cycle, for a quotient length
// given at start. The dividend must stay below den * 2^qbits.
// ----------------------------------------------------------------------------
module qdra_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [qdra_pkg::WIDE_W-1:0]         num,
	input  logic [qdra_pkg::WIDE_W-1:0]         den,
	input  logic [qdra_pkg::QBITS_W-1:0]        qbits,
	output logic [qdra_pkg::QUOT_W-1:0]         quot,
	output qdra_pkg::unit_sts_t                 sts
);

	logic [qdra_pkg::WIDE_W-1:0]  rem_q;
	logic [qdra_pkg::WIDE_W-1:0]  den_sh_q;
	logic [qdra_pkg::QUOT_W-1:0]  quot_q;
	logic [qdra_pkg::QBITS_W-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic                         ge;

	assign ge = rem_q >= den_sh_q;

	// load on start, then take one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				rem_q    <= num;
				den_sh_q <= den << (qbits - qdra_pkg::QBITS_W'(1));
				quot_q   <= '0;
				cnt_q    <= qbits;
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - den_sh_q;
				end
				quot_q   <= {quot_q[qdra_pkg::QUOT_W-2:0], ge};
				den_sh_q <= den_sh_q >> 1;
				cnt_q    <= cnt_q - qdra_pkg::QBITS_W'(1);
				if (cnt_q == qdra_pkg::QBITS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot     = quot_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ src/qdra_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdra_sqrt: iterative integer square root
// Floor square root of a 64-bit radicand, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module qdra_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [qdra_pkg::WIDE_W-1:0]  rad,
	output logic [qdra_pkg::ROOT_W-1:0]  root,
	output qdra_pkg::unit_sts_t          sts
);

	logic [qdra_pkg::WIDE_W-1:0] v_q;
	logic [qdra_pkg::WIDE_W-1:0] r_q;
	logic [qdra_pkg::WIDE_W-1:0] bit_q;
	logic                        busy_q;
	logic                        done_q;
	logic [qdra_pkg::WIDE_W-1:0] rbit;
	logic                        ge;

	assign rbit = r_q + bit_q;
	assign ge   = v_q >= rbit;

	// settle one root bit per cycle, top bit first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				v_q    <= rad;
				r_q    <= '0;
				bit_q  <= qdra_pkg::WIDE_W'(1) << (qdra_pkg::WIDE_W - 2);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					v_q <= v_q - rbit;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root     = r_q[qdra_pkg::ROOT_W-1:0];
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ src/quaternion_delta_rotation_accumulator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_delta_rotation_accumulator_unit: incremental rotation integrator
// Normalizes each orientation sample, forms the body-frame delta against the
// previous sample, turns it into a rotation vector in degrees and adds it to
// saturating roll, pitch and yaw totals.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    restart, quat_w, quat_x, quat_y, quat_z
//   out      out_valid / out_ready  roll_total, pitch_total, yaw_total, was_first
//
// The work per sample is set by the shared square-root unit (up to three roots),
// the shared divider (up to eleven divides) and the single multiplier; a first
// frame ends once the input is normalized.
// in_ready is high only while no sample is in work.
// The result waits in an output register; a stalled output holds the next
// sample back only at its final step.
// Reset restores the identity reference and clears the totals.
// ----------------------------------------------------------------------------
module quaternion_delta_rotation_accumulator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  restart,
	input  logic signed [qdra_pkg::QUAT_W-1:0]    quat_w,
	input  logic signed [qdra_pkg::QUAT_W-1:0]    quat_x,
	input  logic signed [qdra_pkg::QUAT_W-1:0]    quat_y,
	input  logic signed [qdra_pkg::QUAT_W-1:0]    quat_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [qdra_pkg::ANGLE_W-1:0]   roll_total,
	output logic signed [qdra_pkg::ANGLE_W-1:0]   pitch_total,
	output logic signed [qdra_pkg::ANGLE_W-1:0]   yaw_total,
	output logic                                  was_first
);

	localparam int QW = qdra_pkg::QUAT_W;
	localparam int DW = qdra_pkg::DQ_W;
	localparam int WW = qdra_pkg::WIDE_W;
	localparam int MW = qdra_pkg::MUL_W;
	localparam int AW = qdra_pkg::ANGLE_W;
	localparam logic signed [QW-1:0] ONE_Q = QW'(1 << qdra_pkg::QFRAC);
	localparam logic signed [DW-1:0] ONE_D = DW'(1 << qdra_pkg::DFRAC);
	localparam logic signed [AW-1:0] TOT_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0] TOT_MIN = {1'b1, {(AW-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_RT_WAIT, S_NM_START, S_NM_WAIT, S_NM_POST,
		S_FLIP, S_CORDIC, S_DEG, S_INC_START, S_INC_WAIT, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		J_NIN, J_DLT, J_NDL, J_VEC, J_DEG, J_INC
	} job_t;

	state_t state_q;
	job_t   job_q;

	logic signed [QW-1:0]  cur_q [4];
	logic signed [QW-1:0]  last_q [4];
	logic signed [DW-1:0]  d_q [4];
	logic signed [AW-1:0]  tot_q [3];
	logic signed [AW-1:0]  out_tot_q [3];
	logic                  out_valid_q;
	logic                  out_first_q;
	logic                  awaiting_first_q;
	logic                  first_q;
	logic [3:0]            idx_q;
	logic [1:0]            ax_q;
	logic signed [WW-1:0]  acc_q;
	logic signed [WW-1:0]  prod_q;
	logic [qdra_pkg::ROOT_W-1:0] n_q;
	logic [qdra_pkg::ROOT_W-1:0] vn_q;
	logic [qdra_pkg::AQ_W-1:0]   a_q;
	logic signed [qdra_pkg::XY_W-1:0] x_q;
	logic signed [qdra_pkg::XY_W-1:0] y_q;
	logic signed [qdra_pkg::Z_W-1:0]  z_q;
	logic [qdra_pkg::CK_W-1:0]        k_q;

	// operand selection
	logic [1:0]            t_idx;
	logic [1:0]            cur_idx;
	logic [1:0]            d_idx;
	logic signed [QW-1:0]  cur_rd;
	logic signed [QW-1:0]  last_rd;
	logic signed [DW-1:0]  d_rd;
	logic signed [qdra_pkg::Z_W-1:0] z_pos;
	logic signed [MW-1:0]  op_a;
	logic signed [MW-1:0]  op_b;
	logic signed [2*MW-1:0] prod_full;
	logic                  neg_term;
	logic signed [WW-1:0]  acc_n;
	logic                  term_last;

	// shared units
	logic                  sqrt_start;
	logic [qdra_pkg::ROOT_W-1:0] root;
	qdra_pkg::unit_sts_t   sqrt_sts;
	logic                  div_start;
	logic [WW-1:0]         div_num;
	logic [WW-1:0]         div_den;
	logic [qdra_pkg::QBITS_W-1:0] div_qbits;
	logic [qdra_pkg::QUOT_W-1:0]  quot;
	qdra_pkg::unit_sts_t   div_sts;

	// normalize and increment paths
	logic signed [DW-1:0]  comp;
	logic [DW-1:0]         comp_mag;
	logic [WW-1:0]         nm_num;
	logic signed [DW-1:0]  nm_res;
	logic [WW-1:0]         prod_mag;
	logic [WW-1:0]         inc_den;
	logic [WW-1:0]         inc_num;
	logic signed [AW-1:0]  inc_s;
	logic signed [AW-1:0]  tot_rd;
	logic signed [AW:0]    sum_w;
	logic signed [AW-1:0]  tot_sat;

	// CORDIC step
	logic signed [qdra_pkg::XY_W-1:0] xs;
	logic signed [qdra_pkg::XY_W-1:0] ys;
	logic signed [qdra_pkg::Z_W-1:0]  at;
	logic                             y_pos;

	// pick array entries for the current job and term
	always_comb begin
		t_idx   = idx_q[1:0];
		cur_idx = (job_q == J_DLT) ? (idx_q[3:2] ^ t_idx) : t_idx;
		case (job_q)
			J_VEC:   d_idx = t_idx + 2'd1;
			J_INC:   d_idx = ax_q + 2'd1;
			default: d_idx = t_idx;
		endcase
	end

	assign cur_rd  = cur_q[cur_idx];
	assign last_rd = last_q[t_idx];
	assign d_rd    = d_q[d_idx];
	assign z_pos   = z_q[qdra_pkg::Z_W-1] ? '0 : z_q;

	// multiplier operands
	always_comb begin
		case (job_q)
			J_NIN: begin
				op_a = {{(MW-QW){cur_rd[QW-1]}}, cur_rd};
				op_b = op_a;
			end
			J_DLT: begin
				op_a = {{(MW-QW){last_rd[QW-1]}}, last_rd};
				op_b = {{(MW-QW){cur_rd[QW-1]}}, cur_rd};
			end
			J_DEG: begin
				op_a = z_pos;
				op_b = qdra_pkg::DEG_SCALE;
			end
			J_INC: begin
				op_a = {{(MW-DW){d_rd[DW-1]}}, d_rd};
				op_b = {1'b0, a_q};
			end
			default: begin
				op_a = {{(MW-DW){d_rd[DW-1]}}, d_rd};
				op_b = op_a;
			end
		endcase
	end

	assign prod_full = op_a * op_b;
	assign neg_term  = (job_q == J_DLT) && qdra_pkg::DELTA_NEG[idx_q];
	assign acc_n     = neg_term ? (acc_q - prod_q) : (acc_q + prod_q);

	always_comb begin
		case (job_q)
			J_DLT:   term_last = idx_q == 4'd15;
			J_VEC:   term_last = idx_q == 4'd2;
			default: term_last = idx_q == 4'd3;
		endcase
	end

	assign sqrt_start = (state_q == S_ACC) && term_last && (job_q != J_DLT);

	qdra_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (acc_n),
		.root   (root),
		.sts    (sqrt_sts)
	);

	// scaled magnitude of one component for normalizing
	always_comb begin
		comp     = (job_q == J_NIN) ? {{(DW-QW){cur_rd[QW-1]}}, cur_rd} : d_rd;
		comp_mag = comp[DW-1] ? DW'(-comp) : comp;
		if (job_q == J_NIN) begin
			nm_num = (WW'(comp_mag) << qdra_pkg::QFRAC) + WW'(n_q >> 1);
		end else begin
			nm_num = (WW'(comp_mag) << qdra_pkg::DFRAC) + WW'(n_q >> 1);
		end
		nm_res = comp[DW-1] ? DW'(-quot) : DW'(quot);
	end

	// rotation increment for one axis
	always_comb begin
		prod_mag = prod_q[WW-1] ? WW'(-prod_q) : prod_q;
		inc_den  = WW'(vn_q) << qdra_pkg::INC_SHIFT;
		inc_num  = prod_mag + (inc_den >> 1);
		inc_s    = prod_q[WW-1] ? AW'(-quot) : AW'(quot);
		tot_rd   = tot_q[ax_q];
		sum_w    = {tot_rd[AW-1], tot_rd} + {inc_s[AW-1], inc_s};
		if (sum_w[AW] != sum_w[AW-1]) begin
			tot_sat = sum_w[AW] ? TOT_MIN : TOT_MAX;
		end else begin
			tot_sat = sum_w[AW-1:0];
		end
	end

	// divider input for normalizing or for the increment
	always_comb begin
		div_start = (state_q == S_NM_START) || (state_q == S_INC_START);
		if (state_q == S_INC_START) begin
			div_num   = inc_num;
			div_den   = inc_den;
			div_qbits = qdra_pkg::INC_QBITS;
		end else begin
			div_num   = nm_num;
			div_den   = WW'(n_q);
			div_qbits = (job_q == J_NIN) ? qdra_pkg::IN_QBITS : qdra_pkg::DL_QBITS;
		end
	end

	qdra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.qbits  (div_qbits),
		.quot   (quot),
		.sts    (div_sts)
	);

	// one CORDIC vectoring step
	assign xs    = x_q >>> k_q;
	assign ys    = y_q >>> k_q;
	assign at    = {{(qdra_pkg::Z_W-qdra_pkg::ATAN_W){1'b0}}, qdra_pkg::atan_step(k_q)};
	assign y_pos = !y_q[qdra_pkg::XY_W-1] && (y_q != '0);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			job_q            <= J_NIN;
			out_valid_q      <= 1'b0;
			awaiting_first_q <= 1'b1;
			last_q[0]        <= ONE_Q;
			last_q[1]        <= '0;
			last_q[2]        <= '0;
			last_q[3]        <= '0;
			tot_q[0]         <= '0;
			tot_q[1]         <= '0;
			tot_q[2]         <= '0;
			idx_q            <= '0;
			ax_q             <= '0;
			k_q              <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_q[0] <= quat_w;
						cur_q[1] <= quat_x;
						cur_q[2] <= quat_y;
						cur_q[3] <= quat_z;
						first_q  <= restart || awaiting_first_q;
						if (restart) begin
							tot_q[0] <= '0;
							tot_q[1] <= '0;
							tot_q[2] <= '0;
						end
						job_q   <= J_NIN;
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= prod_full[WW-1:0];
					case (job_q)
						J_DEG:   state_q <= S_DEG;
						J_INC:   state_q <= S_INC_START;
						default: state_q <= S_ACC;
					endcase
				end
				S_ACC: begin
					idx_q <= idx_q + 4'd1;
					if (job_q == J_DLT && t_idx == 2'd3) begin
						d_q[idx_q[3:2]] <= acc_n[DW-1:0];
						acc_q           <= '0;
					end else begin
						acc_q <= acc_n;
					end
					if (!term_last) begin
						state_q <= S_MUL;
					end else if (job_q == J_DLT) begin
						job_q   <= J_NDL;
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end else begin
						state_q <= S_RT_WAIT;
					end
				end
				S_RT_WAIT: begin
					if (sqrt_sts.done) begin
						idx_q <= '0;
						if (job_q == J_VEC) begin
							vn_q <= root;
							if (root > qdra_pkg::DELTA_EPS) begin
								x_q     <= {{(qdra_pkg::XY_W-DW){d_q[0][DW-1]}}, d_q[0]};
								y_q     <= {{(qdra_pkg::XY_W-qdra_pkg::ROOT_W){1'b0}}, root};
								z_q     <= '0;
								k_q     <= '0;
								state_q <= S_CORDIC;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							n_q <= root;
							if (job_q == J_NIN && root <= qdra_pkg::IN_EPS) begin
								cur_q[0] <= ONE_Q;
								cur_q[1] <= '0;
								cur_q[2] <= '0;
								cur_q[3] <= '0;
								state_q  <= S_NM_POST;
							end else if (job_q == J_NDL && root <= qdra_pkg::DELTA_EPS) begin
								d_q[0]  <= ONE_D;
								d_q[1]  <= '0;
								d_q[2]  <= '0;
								d_q[3]  <= '0;
								state_q <= S_NM_POST;
							end else begin
								state_q <= S_NM_START;
							end
						end
					end
				end
				S_NM_START: begin
					state_q <= S_NM_WAIT;
				end
				S_NM_WAIT: begin
					if (div_sts.done) begin
						if (job_q == J_NIN) begin
							cur_q[t_idx] <= nm_res[QW-1:0];
						end else begin
							d_q[t_idx] <= nm_res;
						end
						idx_q   <= idx_q + 4'd1;
						state_q <= (t_idx == 2'd3) ? S_NM_POST : S_NM_START;
					end
				end
				S_NM_POST: begin
					idx_q <= '0;
					acc_q <= '0;
					if (job_q == J_NDL) begin
						state_q <= S_FLIP;
					end else if (first_q) begin
						state_q <= S_DONE;
					end else begin
						job_q   <= J_DLT;
						state_q <= S_MUL;
					end
				end
				S_FLIP: begin
					// take the shortest path
					if (d_q[0][DW-1]) begin
						d_q[0] <= -d_q[0];
						d_q[1] <= -d_q[1];
						d_q[2] <= -d_q[2];
						d_q[3] <= -d_q[3];
					end
					job_q   <= J_VEC;
					idx_q   <= '0;
					acc_q   <= '0;
					state_q <= S_MUL;
				end
				S_CORDIC: begin
					if (y_pos) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end
					k_q <= k_q + qdra_pkg::CK_W'(1);
					if (k_q == qdra_pkg::CK_W'(qdra_pkg::CORDIC_STEPS - 1)) begin
						job_q   <= J_DEG;
						state_q <= S_MUL;
					end
				end
				S_DEG: begin
					a_q     <= prod_q[qdra_pkg::DEG_SHIFT + qdra_pkg::AQ_W - 1 -: qdra_pkg::AQ_W];
					ax_q    <= '0;
					job_q   <= J_INC;
					state_q <= S_MUL;
				end
				S_INC_START: begin
					state_q <= S_INC_WAIT;
				end
				S_INC_WAIT: begin
					if (div_sts.done) begin
						tot_q[ax_q] <= tot_sat;
						ax_q        <= ax_q + 2'd1;
						state_q     <= (ax_q == 2'd2) ? S_DONE : S_MUL;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_tot_q[0]     <= tot_q[0];
						out_tot_q[1]     <= tot_q[1];
						out_tot_q[2]     <= tot_q[2];
						out_first_q      <= first_q;
						out_valid_q      <= 1'b1;
						last_q[0]        <= cur_q[0];
						last_q[1]        <= cur_q[1];
						last_q[2]        <= cur_q[2];
						last_q[3]        <= cur_q[3];
						awaiting_first_q <= 1'b0;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = state_q == S_IDLE;
	assign out_valid   = out_valid_q;
	assign roll_total  = out_tot_q[0];
	assign pitch_total = out_tot_q[1];
	assign yaw_total   = out_tot_q[2];
	assign was_first   = out_first_q;

	// a transfer in starts work at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in work");

	// restart clears the totals
	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && restart |=>
		tot_q[0] == '0 && tot_q[1] == '0 && tot_q[2] == '0)
		else $error("totals not cleared on restart");

	// nothing is added before the first reference exists
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_first_q |-> tot_q[0] == '0 && tot_q[1] == '0 && tot_q[2] == '0)
		else $error("totals moved before the first sample");

	// the divider is idle whenever a divide is issued
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NM_START || state_q == S_INC_START |-> !div_sts.busy)
		else $error("divide issued while divider busy");

	// the CORDIC step index stays below CORDIC_STEPS
	a_cordic_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CORDIC |-> k_q < qdra_pkg::CK_W'(qdra_pkg::CORDIC_STEPS))
		else $error("CORDIC step count overrun");

endmodule
